>>> design/ray_dda_setup_defines.svh
// Assertion macros for the ray setup block
`ifndef RAY_DDA_SETUP_DEFINES_SVH
`define RAY_DDA_SETUP_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define RDS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked in reset as well
`define RDS_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/rds_pkg.sv
// ----------------------------------------------------------------------------
// rds_pkg
// Types, constants and helpers for the ray setup pipeline.
// ----------------------------------------------------------------------------
package rds_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int SCREEN_WIDTH = 1024;
   localparam int DIV_STAGES   = 24;

   localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
   localparam logic [18:0] REM_INIT = 19'd256;  // 2^32 >> 24

   typedef enum logic [2:0] {
      CSR_POS_X   = 3'd0,
      CSR_POS_Y   = 3'd1,
      CSR_DIR_X   = 3'd2,
      CSR_DIR_Y   = 3'd3,
      CSR_PLANE_X = 3'd4,
      CSR_PLANE_Y = 3'd5
   } csr_index_type;

   // one axis travelling down the divider chain
   typedef struct packed {
      logic signed [18:0] ray;
      logic [18:0]        mag;
      logic [18:0]        rem;
      logic [23:0]        q;
      logic               sat;
   } rds_lane_type;

   typedef struct packed {
      rds_lane_type x;
      rds_lane_type y;
   } rds_word_type;

   // one restoring step: one quotient bit
   function automatic rds_lane_type rds_div_step(input rds_lane_type a);
      rds_lane_type r;
      logic [19:0]  rem2;
      r    = a;
      rem2 = {a.rem, 1'b0};
      if (rem2 >= {1'b0, a.mag}) begin
         r.rem = 19'(rem2 - {1'b0, a.mag});
         r.q   = {a.q[22:0], 1'b1};
      end else begin
         r.rem = rem2[18:0];
         r.q   = {a.q[22:0], 1'b0};
      end
      return r;
   endfunction

endpackage

>>> design/rds_div_cell.sv
// ----------------------------------------------------------------------------
// rds_div_cell
// One divider cell: a quotient bit for both axes, one word held.
// ----------------------------------------------------------------------------
module rds_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  rds_pkg::rds_word_type up_word,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output rds_pkg::rds_word_type dn_word
);
   import rds_pkg::*;

   logic         valid_ff;
   rds_word_type word_ff, word_in;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

   always_comb begin
      word_in.x = rds_div_step(up_word.x);
      word_in.y = rds_div_step(up_word.y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

>>> design/ray_dda_setup.sv
// ----------------------------------------------------------------------------
// ray_dda_setup
// Per-column ray setup for a grid DDA ray caster.
// ----------------------------------------------------------------------------
//  channel | ports          | flow
//  --------+----------------+---------------------------------
//  request | req_*          | valid/ready, one column per word
//  result  | rsp_*          | valid/ready, one setup word each
//  config  | csr_*          | write enable, no wait
//
// One word per cycle sustained while rsp_ready is high; stages: column
// register, plane multiply, ray sum, 24 divider cells (one quotient bit
// each), side multiply and output register. Each stage holds its own
// valid, so bubbles close up and new columns enter while a result waits.
// Reset is synchronous: valid bits clear, config registers take defaults.
// ----------------------------------------------------------------------------
`include "ray_dda_setup_defines.svh"

module ray_dda_setup (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [9:0]         req_column,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [18:0] rsp_ray_x,
   output logic signed [18:0] rsp_ray_y,
   output logic [6:0]         rsp_cell_x,
   output logic [6:0]         rsp_cell_y,
   output logic               rsp_step_x_negative,
   output logic               rsp_step_y_negative,
   output logic [23:0]        rsp_delta_x,
   output logic [23:0]        rsp_delta_y,
   output logic [23:0]        rsp_side_x,
   output logic [23:0]        rsp_side_y,
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [22:0]        csr_wdata
);
   import rds_pkg::*;

   // config registers
   logic [22:0]        pos_x_ff, pos_y_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         dir_x_ff   <= 18'sd65536;
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= 18'sd43253;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_POS_X:   pos_x_ff   <= csr_wdata;
            CSR_POS_Y:   pos_y_ff   <= csr_wdata;
            CSR_DIR_X:   dir_x_ff   <= csr_wdata[17:0];
            CSR_DIR_Y:   dir_y_ff   <= csr_wdata[17:0];
            CSR_PLANE_X: plane_x_ff <= csr_wdata[17:0];
            CSR_PLANE_Y: plane_y_ff <= csr_wdata[17:0];
            default: ;
         endcase
      end
   end

   // ready chain, back to front
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
   logic chain_up_rdy, chain_dn_v;
   rds_word_type chain_dn_word;

   assign s5_rdy    = !s5_v_ff || rsp_ready;
   assign s4_rdy    = !s4_v_ff || s5_rdy;
   assign s3_rdy    = !s3_v_ff || chain_up_rdy;
   assign s2_rdy    = !s2_v_ff || s3_rdy;
   assign s1_rdy    = !s1_v_ff || s2_rdy;
   assign req_ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_v_ff <= req_valid;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
         if (s4_rdy) s4_v_ff <= chain_dn_v;
         if (s5_rdy) s5_v_ff <= s4_v_ff;
      end
   end

   // stage 1: column
   logic [9:0] col_ff;
   always_ff @(posedge clock) begin
      if (s1_rdy && req_valid) col_ff <= req_column;
   end

   // stage 2: camera coordinate times plane
   logic [18:0]        cx_scaled;
   logic signed [18:0] cx_wide;
   logic signed [17:0] cx;
   logic signed [35:0] prod_x_ff, prod_y_ff, prod_x_in, prod_y_in;

   always_comb begin
      cx_scaled = 19'({1'b0, col_ff, 17'b0} / SCREEN_WIDTH);
      cx_wide   = signed'(cx_scaled) - 19'sd65536;
      cx        = cx_wide[17:0];
      prod_x_in = plane_x_ff * cx;
      prod_y_in = plane_y_ff * cx;
   end

   always_ff @(posedge clock) begin
      if (s2_rdy && s1_v_ff) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
   end

   // stage 3: ray, magnitude, divider seed
   function automatic rds_lane_type seed(input logic signed [17:0] dir,
                                         input logic signed [35:0] prod);
      rds_lane_type       l;
      logic signed [20:0] sum;
      logic signed [18:0] ray;
      sum = 21'(dir) + 21'(signed'(prod[35:FRAC_BITS]));
      if (sum > 21'sd262143)       ray = 19'sd262143;
      else if (sum < -21'sd262144) ray = -19'sd262144;
      else                         ray = sum[18:0];
      l.ray = ray;
      l.mag = ray[18] ? 19'(-ray) : ray;
      l.rem = REM_INIT;
      l.q   = '0;
      l.sat = (l.mag <= 19'd256);   // quotient would pass 24 bits, or zero
      return l;
   endfunction

   rds_word_type s3_word_ff;
   always_ff @(posedge clock) begin
      if (s3_rdy && s2_v_ff) begin
         s3_word_ff.x <= seed(dir_x_ff, prod_x_ff);
         s3_word_ff.y <= seed(dir_y_ff, prod_y_ff);
      end
   end

   // divider chain
   logic         cv [DIV_STAGES+1];
   logic         cr [DIV_STAGES+1];
   rds_word_type cw [DIV_STAGES+1];

   assign cv[0]         = s3_v_ff;
   assign cw[0]         = s3_word_ff;
   assign chain_up_rdy  = cr[0];
   assign chain_dn_v    = cv[DIV_STAGES];
   assign chain_dn_word = cw[DIV_STAGES];
   assign cr[DIV_STAGES] = s4_rdy;

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_cell
      rds_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cv[i]),
         .up_ready (cr[i]),
         .up_word  (cw[i]),
         .dn_valid (cv[i+1]),
         .dn_ready (cr[i+1]),
         .dn_word  (cw[i+1])
      );
   end

   // stage 4: delta and fraction product
   function automatic logic [16:0] first_frac(input logic [22:0] pos, input logic neg);
      return neg ? {1'b0, pos[15:0]} : 17'(17'd65536 - {1'b0, pos[15:0]});
   endfunction

   logic [23:0]        dx_in, dy_in, dx_ff, dy_ff;
   logic [40:0]        sp_x_ff, sp_y_ff;
   logic signed [18:0] rx4_ff, ry4_ff;

   assign dx_in = chain_dn_word.x.sat ? DIST_MAX : chain_dn_word.x.q;
   assign dy_in = chain_dn_word.y.sat ? DIST_MAX : chain_dn_word.y.q;

   always_ff @(posedge clock) begin
      if (s4_rdy && chain_dn_v) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         rx4_ff  <= chain_dn_word.x.ray;
         ry4_ff  <= chain_dn_word.y.ray;
         sp_x_ff <= first_frac(pos_x_ff, chain_dn_word.x.ray[18]) * dx_in;
         sp_y_ff <= first_frac(pos_y_ff, chain_dn_word.y.ray[18]) * dy_in;
      end
   end

   // stage 5: output register
   function automatic logic [23:0] side_sat(input logic [40:0] p);
      return (p[40:40] != 1'b0) ? DIST_MAX : p[39:16];
   endfunction

   logic signed [18:0] rx_ff, ry_ff;
   logic [23:0]        dxo_ff, dyo_ff, sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (s5_rdy && s4_v_ff) begin
         rx_ff  <= rx4_ff;
         ry_ff  <= ry4_ff;
         dxo_ff <= dx_ff;
         dyo_ff <= dy_ff;
         sx_ff  <= side_sat(sp_x_ff);
         sy_ff  <= side_sat(sp_y_ff);
      end
   end

   assign rsp_valid           = s5_v_ff;
   assign rsp_ray_x           = rx_ff;
   assign rsp_ray_y           = ry_ff;
   assign rsp_cell_x          = pos_x_ff[22:16];
   assign rsp_cell_y          = pos_y_ff[22:16];
   assign rsp_step_x_negative = rx_ff[18];
   assign rsp_step_y_negative = ry_ff[18];
   assign rsp_delta_x         = dxo_ff;
   assign rsp_delta_y         = dyo_ff;
   assign rsp_side_x          = sx_ff;
   assign rsp_side_y          = sy_ff;

   // checks
   `RDS_ASSERT_IMP(a_zero_ray_x, clock, reset, rsp_valid && rsp_ray_x == 19'sd0, rsp_delta_x == DIST_MAX, "zero ray x must saturate delta")
   `RDS_ASSERT_IMP(a_zero_ray_y, clock, reset, rsp_valid && rsp_ray_y == 19'sd0, rsp_delta_y == DIST_MAX, "zero ray y must saturate delta")
   `RDS_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid && req_ready, "pipeline not empty after reset")

endmodule
